// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-edge implication
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-edge implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/fbfla_pkg.sv -----
// ----------------------------------------------------------------------------
// fbfla_pkg
// shared types and constants of the fixed block free list allocator
// ----------------------------------------------------------------------------
package fbfla_pkg;

    localparam int IDX_W          = 10;
    localparam int OFF_W          = 22;
    localparam int BB_W           = 13;
    localparam int FRESH_W        = 11;
    localparam int MAX_BLOCKS     = 1024;
    localparam int NUM_BLOCKS_DEF = 1024;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [BB_W-1:0] BB_MIN   = 13'd8;
    localparam logic [BB_W-1:0] BB_MAX   = 13'd4096;
    localparam logic [BB_W-1:0] BB_RESET = 13'd64;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_EXHAUSTED = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_BLOCK_BYTES = '0;

    typedef struct packed {
        logic accept;
        logic finish;
    } t_fbfla_cmd;

endpackage

// ----- rtl/fbfla_ram.sv -----
// ----------------------------------------------------------------------------
// fbfla_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fbfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fbfla_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbfla_ctrl
// command sequencer and result register handshake
// ----------------------------------------------------------------------------
module fbfla_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output fbfla_pkg::t_fbfla_cmd  o_cmd
);

    import fbfla_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.finish = (r_state == S_EXEC) && slot_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/fbfla_dp.sv -----
// ----------------------------------------------------------------------------
// fbfla_dp
// free list head, link ram, fresh block counter, offset multiply, config
// ----------------------------------------------------------------------------
module fbfla_dp #(
    parameter int NUM_BLOCKS = fbfla_pkg::NUM_BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fbfla_pkg::t_fbfla_cmd          i_cmd,
    input  logic                           i_in_kind,
    input  logic [fbfla_pkg::IDX_W-1:0]    i_in_index,
    output logic [fbfla_pkg::IDX_W-1:0]    o_out_index,
    output logic [fbfla_pkg::OFF_W-1:0]    o_out_offset,
    output logic                           o_out_status,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [fbfla_pkg::APB_AW-1:0]   i_paddr,
    input  logic [fbfla_pkg::APB_DW-1:0]   i_pwdata,
    output logic [fbfla_pkg::APB_DW-1:0]   o_prdata
);

    import fbfla_pkg::*;

    localparam int CAP = (NUM_BLOCKS > MAX_BLOCKS) ? MAX_BLOCKS : NUM_BLOCKS;
    localparam int AW  = $clog2(CAP);
    localparam int LW  = IDX_W + 1;
    localparam int PW  = IDX_W + BB_W;
    localparam logic [FRESH_W-1:0] CAP_F = FRESH_W'(CAP);

    logic [BB_W-1:0]    r_block_bytes;
    logic               r_kind;
    logic [IDX_W-1:0]   r_index;
    logic [IDX_W-1:0]   r_free_head;
    logic               r_free_nonempty;
    logic [FRESH_W-1:0] r_fresh_count;
    logic [IDX_W-1:0]   r_out_index;
    logic [OFF_W-1:0]   r_out_offset;
    logic               r_out_status;

    logic [REG_IDX_W-1:0] reg_sel;
    logic                 cfg_we;
    logic                 in_range;
    logic                 link_we;
    logic [LW-1:0]        link_rdata;
    logic [BB_W-1:0]      eff_bytes;
    logic [IDX_W-1:0]     sel_index;
    logic                 sel_status;
    logic [PW-1:0]        product;

    assign reg_sel = i_paddr[APB_AW-1:2];
    assign cfg_we  = i_psel && i_penable && i_pwrite && (reg_sel == REG_BLOCK_BYTES);

    always_comb begin
        unique case (reg_sel)
            REG_BLOCK_BYTES: o_prdata = {{(APB_DW-BB_W){1'b0}}, r_block_bytes};
            default:         o_prdata = '0;
        endcase
    end

    assign in_range = ({1'b0, i_in_index} < CAP_F);
    assign link_we  = i_cmd.accept && (i_in_kind == CMD_FREE) && in_range;

    // link entry: successor-valid flag above successor index
    fbfla_ram #(
        .WIDTH (LW),
        .DEPTH (CAP)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (i_in_index[AW-1:0]),
        .i_wdata ({r_free_nonempty, r_free_head}),
        .i_raddr (r_free_head[AW-1:0]),
        .o_rdata (link_rdata)
    );

    always_comb begin
        eff_bytes = r_block_bytes;
        if (r_block_bytes < BB_MIN) begin
            eff_bytes = BB_MIN;
        end else if (r_block_bytes > BB_MAX) begin
            eff_bytes = BB_MAX;
        end
    end

    always_comb begin
        sel_index  = r_index;
        sel_status = ST_OK;
        if (r_kind == CMD_ALLOC) begin
            if (r_free_nonempty) begin
                sel_index = r_free_head;
            end else if (r_fresh_count < CAP_F) begin
                sel_index = r_fresh_count[IDX_W-1:0];
            end else begin
                sel_index  = '0;
                sel_status = ST_EXHAUSTED;
            end
        end
    end

    assign product = {{BB_W{1'b0}}, sel_index} * {{IDX_W{1'b0}}, eff_bytes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes   <= BB_RESET;
            r_free_head     <= '0;
            r_free_nonempty <= 1'b0;
            r_fresh_count   <= '0;
        end else begin
            if (cfg_we) begin
                r_block_bytes <= i_pwdata[BB_W-1:0];
            end
            if (link_we) begin
                r_free_head     <= i_in_index;
                r_free_nonempty <= 1'b1;
            end
            if (i_cmd.finish && (r_kind == CMD_ALLOC)) begin
                if (r_free_nonempty) begin
                    r_free_head     <= link_rdata[IDX_W-1:0];
                    r_free_nonempty <= link_rdata[IDX_W];
                end else if (r_fresh_count < CAP_F) begin
                    r_fresh_count <= r_fresh_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_in_kind;
            r_index <= i_in_index;
        end
        if (i_cmd.finish) begin
            r_out_index  <= sel_index;
            r_out_offset <= product[OFF_W-1:0];
            r_out_status <= sel_status;
        end
    end

    assign o_out_index  = r_out_index;
    assign o_out_offset = r_out_offset;
    assign o_out_status = r_out_status;

endmodule

// ----- rtl/fixed_block_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top
// pool allocator of equal sized blocks with a lifo free list
// ----------------------------------------------------------------------------
// Each command is accepted in the idle state, which launches the read of the
// head block's successor link from the link ram; the execute state then uses
// the registered read data to pop the list, picks the block and forms its byte
// offset into the result register. A new command is taken while a finished
// result waits; a command stays in the execute state only while the result
// register is still full. Frees push onto the list head, allocates pop it or
// else hand out the next never-used block; with both gone the result reports
// exhaustion with index and offset zero. No clearing pass follows reset.
module fixed_block_free_list_allocator_top #(
    parameter int NUM_BLOCKS = fbfla_pkg::NUM_BLOCKS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fbfla_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // block_index, zero pad
    input  logic                               s_axis_tuser,  // cmd
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fbfla_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // given_index, given_offset
    output logic                               m_axis_tuser,  // status
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fbfla_pkg::APB_AW-1:0]       paddr,
    input  logic [fbfla_pkg::APB_DW-1:0]       pwdata,
    output logic [fbfla_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);

    import fbfla_pkg::*;

    t_fbfla_cmd       cmd;
    logic [IDX_W-1:0] out_index;
    logic [OFF_W-1:0] out_offset;

    assign pready = 1'b1;

    fbfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    fbfla_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_in_kind    (s_axis_tuser),
        .i_in_index   (s_axis_tdata[IDX_W-1:0]),
        .o_out_index  (out_index),
        .o_out_offset (out_offset),
        .o_out_status (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_prdata     (prdata)
    );

    assign m_axis_tdata = {out_offset, out_index};

endmodule

// ----- rtl/fbfla_checker.sv -----
// ----------------------------------------------------------------------------
// fbfla_checker
// port level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbfla_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fbfla_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    `AST_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `AST_IMPL(a_exhaust_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `AST_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `AST_IMPL(a_result_has_cause, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind fixed_block_free_list_allocator_top fbfla_checker u_checker (.*);
